[rtl/core/glu_pkg.sv]
`default_nettype none

package glu_pkg;

    // Q4.12 element format
    localparam int DATA_W = 16;
    localparam int FRAC_W = 12;

    // sigmoid table: 16 equal segments over the full input range
    localparam int SEG_N  = 16;
    localparam int SEG_W  = 4;
    localparam int OFF_W  = DATA_W - SEG_W;
    localparam int ROM_N  = SEG_N + 1;
    localparam int ROM_AW = 5;

    // internal widths
    localparam int SIG_W  = FRAC_W;       // s(a) lies in [1, 4095]
    localparam int DY_W   = 10;           // largest step between table entries is 946
    localparam int DRV_W  = 11;           // s*(1-s) never exceeds 1024
    localparam int WIDE_W = 20;           // rescaled products before saturation

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [SIG_W-1:0]         t_sig;
    typedef t_sig                     t_rom [ROM_N];

    // sigmoid at breakpoints x = -8 .. +8, rounded to nearest at 12 fraction bits
    localparam t_rom SIG_ROM = '{
        12'd1,    12'd4,    12'd10,   12'd27,   12'd74,   12'd194,
        12'd488,  12'd1102, 12'd2048, 12'd2994, 12'd3608, 12'd3902,
        12'd4022, 12'd4069, 12'd4086, 12'd4092, 12'd4095
    };

    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(2 ** (DATA_W - 1) - 1);
    localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(-(2 ** (DATA_W - 1)));

    // fields that ride along with the gate value through the sigmoid stages
    typedef struct packed {
        logic  func;
        t_data lin;
        t_data grad;
    } t_side;

    // beat between the sigmoid and the gradient units
    typedef struct packed {
        t_sig  s;
        t_side side;
    } t_sig_beat;

    // result beat
    typedef struct packed {
        logic  gvld;
        t_data lin_grad;
        t_data out_gate;
    } t_res;

    function automatic t_data sat_data(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/glu_sigmoid.sv]
`default_nettype none

module glu_sigmoid
    import glu_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_data     i_gate,
    input  wire t_side     i_side,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_sig_beat      o_beat
);

    // stage A: table lookup
    logic                r_a_vld;
    t_sig                r_a_y0;
    logic [DY_W-1:0]     r_a_dy;
    logic [OFF_W-1:0]    r_a_off;
    t_side               r_a_side;

    // stage B: interpolation
    logic                r_b_vld;
    t_sig                r_b_s;
    t_side               r_b_side;

    logic                a_rdy;
    logic                b_rdy;
    logic [DATA_W-1:0]   u;
    logic [ROM_AW-1:0]   idx0;
    logic [ROM_AW-1:0]   idx1;
    t_sig                y0;
    t_sig                y1;
    logic [DY_W-1:0]     n_dy;
    logic [DY_W+OFF_W-1:0] interp;
    t_sig                n_s;

    // per-stage ready: a stage moves when it is empty or its successor moves
    assign b_rdy   = !r_b_vld || i_ready;
    assign a_rdy   = !r_a_vld || b_rdy;
    assign o_ready = a_rdy;

    // offset-binary input: top bits pick the segment, the rest is the offset
    assign u    = {~i_gate[DATA_W-1], i_gate[DATA_W-2:0]};
    assign idx0 = {1'b0, u[DATA_W-1 -: SEG_W]};
    assign idx1 = idx0 + ROM_AW'(1);
    assign y0   = SIG_ROM[idx0];
    assign y1   = SIG_ROM[idx1];
    assign n_dy = DY_W'(y1 - y0);

    // table is increasing, so the floor of the slope term is a plain shift
    assign interp = r_a_dy * r_a_off;
    assign n_s    = r_a_y0 + SIG_W'(interp >> OFF_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (a_rdy) begin
                r_a_vld <= i_valid;
            end
            if (b_rdy) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_valid) begin
            r_a_y0   <= y0;
            r_a_dy   <= n_dy;
            r_a_off  <= u[OFF_W-1:0];
            r_a_side <= i_side;
        end
        if (b_rdy && r_a_vld) begin
            r_b_s    <= n_s;
            r_b_side <= r_a_side;
        end
    end

    assign o_valid     = r_b_vld;
    assign o_beat.s    = r_b_s;
    assign o_beat.side = r_b_side;

`ifndef ASSERT_OFF
    // the interpolated sigmoid never reaches zero
    a_sig_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> (r_b_s != '0))
        else $error("sigmoid output is zero");

    // a stalled lookup beat is kept, not dropped
    a_stage_a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && !b_rdy) |=> r_a_vld)
        else $error("stage A beat lost under stall");
`endif

endmodule

`default_nettype wire

[rtl/core/glu_grad.sv]
`default_nettype none

module glu_grad
    import glu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_first_layer,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_sig_beat  i_beat,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_res            o_res
);

    // stage C: products with s(a) and g*b
    logic                       r_c_vld;
    logic                       r_c_func;
    logic signed [WIDE_W-1:0]   r_c_fwd;
    logic signed [WIDE_W-1:0]   r_c_lg;
    logic signed [WIDE_W-1:0]   r_c_gb;
    logic [DRV_W-1:0]           r_c_d;

    // stage D: gate gradient, saturation and result select
    logic                       r_d_vld;
    t_res                       r_d_res;

    logic                       c_rdy;
    logic                       d_rdy;
    logic signed [SIG_W:0]      s_ext;
    logic [SIG_W:0]             comp_w;
    logic [2*SIG_W-1:0]         dprod;
    logic signed [SIG_W+DATA_W:0] fwd_p;
    logic signed [SIG_W+DATA_W:0] lg_p;
    logic signed [2*DATA_W-1:0] gb_p;
    logic signed [WIDE_W+DRV_W:0] gg_p;
    logic signed [WIDE_W-1:0]   gg;
    t_res                       n_res;

    assign d_rdy   = !r_d_vld || i_ready;
    assign c_rdy   = !r_c_vld || d_rdy;
    assign o_ready = c_rdy;

    // stage C products, each rescaled with floor rounding
    assign s_ext  = $signed({1'b0, i_beat.s});
    assign comp_w = (SIG_W + 1)'(2 ** FRAC_W) - {1'b0, i_beat.s};
    assign dprod  = i_beat.s * comp_w[SIG_W-1:0];
    assign fwd_p  = s_ext * i_beat.side.lin;
    assign lg_p   = s_ext * i_beat.side.grad;
    assign gb_p   = i_beat.side.grad * i_beat.side.lin;

    // stage D: (g*b) * s'(a)
    assign gg_p = r_c_gb * $signed({1'b0, r_c_d});
    assign gg   = WIDE_W'(gg_p >>> FRAC_W);

    always_comb begin
        n_res = '0;
        if (!r_c_func) begin
            n_res.out_gate = sat_data(r_c_fwd);
        end else if (!i_first_layer) begin
            n_res.out_gate = sat_data(gg);
            n_res.lin_grad = sat_data(r_c_lg);
            n_res.gvld     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (c_rdy) begin
                r_c_vld <= i_valid;
            end
            if (d_rdy) begin
                r_d_vld <= r_c_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_rdy && i_valid) begin
            r_c_func <= i_beat.side.func;
            r_c_fwd  <= WIDE_W'(fwd_p >>> FRAC_W);
            r_c_lg   <= WIDE_W'(lg_p >>> FRAC_W);
            r_c_gb   <= WIDE_W'(gb_p >>> FRAC_W);
            r_c_d    <= dprod[FRAC_W+DRV_W-1:FRAC_W];
        end
        if (d_rdy && r_c_vld) begin
            r_d_res <= n_res;
        end
    end

    assign o_valid = r_d_vld;
    assign o_res   = r_d_res;

`ifndef ASSERT_OFF
    // derivative term is bounded by one quarter
    a_deriv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> (r_c_d <= DRV_W'(2 ** (FRAC_W - 2))))
        else $error("sigmoid derivative out of range");

    // a forward beat never flags gradients
    a_fwd_no_grad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && d_rdy && !r_c_func) |=> !r_d_res.gvld)
        else $error("forward beat flagged as gradient");

    // without gradients the linear gradient is zero
    a_lg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_vld && !r_d_res.gvld) |-> (r_d_res.lin_grad == '0))
        else $error("linear gradient set without gradient flag");
`endif

endmodule

`default_nettype wire

[rtl/core/glu_activation_fwd_bwd.sv]
// Gated linear unit with a sigmoid gate, one Q4.12 element pair per beat. Forward
// beats (tuser = 0) return s(a)*b; backward beats (tuser = 1) return g*b*s(a)*(1-s(a))
// and g*s(a) with the gradient flag set, or zeros with the flag clear when first_layer
// is written to 1. The sigmoid is a 16-segment piecewise-linear table lookup. The
// block is a four-stage pipeline (lookup, interpolation, products, gate product with
// saturation) and takes one beat per cycle unless m_axis_tready back-pressure has filled
// all stages. Each stage has its own ready, so input beats keep flowing into empty stages
// while a result waits at the output. Write first_layer only while the pipeline is empty.
`default_nettype none

module glu_activation_fwd_bwd
    import glu_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [3*DATA_W-1:0]    s_axis_tdata,  // gate_value, linear_value, grad_out
    input  wire logic                   s_axis_tuser,  // func
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [2*DATA_W-1:0]         m_axis_tdata,  // out_or_gate_grad, linear_grad
    output logic                        m_axis_tuser   // gradient_valid
);

    logic       r_first_layer;
    t_side      side;
    logic       sig_vld;
    logic       sig_rdy;
    t_sig_beat  sig_beat;
    t_res       res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_layer <= 1'b0;
        end else if (i_cfg_we) begin
            r_first_layer <= i_cfg_wdata;
        end
    end

    assign side.func = s_axis_tuser;
    assign side.lin  = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign side.grad = s_axis_tdata[3*DATA_W-1:2*DATA_W];

    glu_sigmoid u_sigmoid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_gate  (s_axis_tdata[DATA_W-1:0]),
        .i_side  (side),
        .o_valid (sig_vld),
        .i_ready (sig_rdy),
        .o_beat  (sig_beat)
    );

    glu_grad u_grad (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_first_layer (r_first_layer),
        .i_valid       (sig_vld),
        .o_ready       (sig_rdy),
        .i_beat        (sig_beat),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_res         (res)
    );

    assign m_axis_tdata = {res.lin_grad, res.out_gate};
    assign m_axis_tuser = res.gvld;

endmodule

`default_nettype wire
